@@ rtl/lcsm_pkg.sv @@
// Shared types and constants for the linear concatenation sector mapper.
// Used by lcsm_ctrl, lcsm_dp and linear_concat_sector_mapper_core.
`timescale 1ns / 1ps

package lcsm_pkg;

    localparam int MAX_DISKS_DEF = 8;

    // Field widths of the stream payloads.
    localparam int ACT_W    = 2;
    localparam int SIZE_W   = 40;
    localparam int OFS_W    = 40;
    localparam int START_W  = 44;
    localparam int LEN_W    = 23;
    localparam int IDX_OUT_W = 3;
    localparam int DSEC_W   = 41;
    localparam int STAT_W   = 2;

    // Internal widths: running block total, block end, sector cursor.
    localparam int TOTAL_W  = 43;
    localparam int END_W    = TOTAL_W + 1;
    localparam int SEC_W    = END_W + 1;
    localparam int SECREM_W = SEC_W + 1;

    localparam int IN_FIELDS_W  = SIZE_W + OFS_W + START_W + LEN_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = IDX_OUT_W + DSEC_W + LEN_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Bit positions inside s_tdata and m_tdata.
    localparam int IN_SIZE_LO  = 0;
    localparam int IN_OFS_LO   = IN_SIZE_LO + SIZE_W;
    localparam int IN_START_LO = IN_OFS_LO + OFS_W;
    localparam int IN_LEN_LO   = IN_START_LO + START_W;

    // Request kinds carried on s_tuser.
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MAP   = 2'd2;

    // Result status carried on m_tuser.
    localparam logic [STAT_W-1:0] STAT_MAPPED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ADDED  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    typedef struct packed {
        logic load;
        logic clear;
        logic add;
        logic lookup;
        logic emit;
    } lcsm_cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_last;
    } lcsm_sts_t;

endpackage

@@ rtl/linear_concat_sector_mapper_core.sv @@
// Top level of the linear concatenation sector mapper.
// Depends on lcsm_pkg, lcsm_ctrl and lcsm_dp.
//
//  Channel | Signals                          | Carries
//  --------+----------------------------------+------------------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser | add disk, clear table or map request
//  m_*     | m_tvalid m_tready m_tdata m_tuser | one result per disk added or segment,
//          | m_tlast                          | m_tlast on the last result of a request
//
// A request is taken only in the idle state. A clear completes as it is taken, add disk
// passes through the add state, and a map request yields at most MAX_DISKS + 1 segments:
// each segment passes through a registered compare against every table entry
// and then through selecting the lowest matching disk and writing the result register.
// A stalled m_tready holds the add or segment step until the result register frees.
// Reset clears the disk count, block total, split count and output valid; there is no table clearing pass.
`timescale 1ns / 1ps

module linear_concat_sector_mapper_core
    import lcsm_pkg::*;
#(
    parameter int MAX_DISKS = MAX_DISKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // disk_size_kib, disk_data_offset, start_sector, length_sectors, zero padding
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [ACT_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // disk_index, device_sector, segment_sectors, zero padding
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [STAT_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    lcsm_cmd_t cmd;
    lcsm_sts_t sts;

    lcsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcsm_dp #(
        .MAX_DISKS (MAX_DISKS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/lcsm_ctrl.sv @@
// Controller state machine of the sector mapper.
// Depends on lcsm_pkg; drives the command struct of lcsm_dp.
`timescale 1ns / 1ps

module lcsm_ctrl
    import lcsm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ACT_W-1:0] s_tuser,
    input  lcsm_sts_t        sts,
    output lcsm_cmd_t        cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ADD    = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    case (s_tuser)
                        ACT_ADD:   state_next = ST_ADD;
                        ACT_CLEAR: cmd.clear = 1'b1;
                        ACT_MAP:   state_next = ST_LOOKUP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (sts.out_free)
                begin
                    cmd.add    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.emit_last ? ST_IDLE : ST_LOOKUP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A segment is only produced from a freshly registered table compare.
    a_emit_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> $past(state_reg) == ST_LOOKUP
                              || $past(state_reg) == ST_EMIT)
        else $error("emit state entered without a lookup");

endmodule

@@ rtl/lcsm_dp.sv @@
// Datapath of the sector mapper: disk table, segment cursor and result register.
// Depends on lcsm_pkg; steered by lcsm_ctrl through lcsm_cmd_t.
`timescale 1ns / 1ps

module lcsm_dp
    import lcsm_pkg::*;
#(
    parameter int MAX_DISKS = MAX_DISKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  lcsm_cmd_t             cmd,
    output lcsm_sts_t             sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [STAT_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
    localparam int CNT_W = $clog2(MAX_DISKS + 1);

    // Disk table. Only entries below the disk count are ever compared.
    logic [TOTAL_W-1:0] start_reg [MAX_DISKS];
    logic [END_W-1:0]   end_reg   [MAX_DISKS];
    logic [DSEC_W-1:0]  adj_reg   [MAX_DISKS];
    logic [CNT_W-1:0]   count_reg;
    logic [TOTAL_W-1:0] total_reg;

    // Request in progress.
    logic [SIZE_W-1:0]    size_reg;
    logic [OFS_W-1:0]     offset_reg;
    logic [SEC_W-1:0]     sec_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [SECREM_W-1:0]  secrem_reg;
    logic [MAX_DISKS-1:0] hit_reg;

    // Result register.
    logic                 m_tvalid_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [DSEC_W-1:0]    out_dsec_reg;
    logic [LEN_W-1:0]     out_seg_reg;
    logic [STAT_W-1:0]    out_stat_reg;
    logic                 out_last_reg;

    logic                 table_full;
    logic [END_W-1:0]     new_end;
    logic [DSEC_W-1:0]    new_adj;
    logic [IDX_W+2:0]     add_idx_ext;
    logic [START_W-1:0]   block;
    logic                 n_ok;
    logic [MAX_DISKS-1:0] below_vec;
    logic [MAX_DISKS-1:0] hit_next;
    logic [MAX_DISKS-1:0] first_hit;
    logic                 hit_any;
    logic [END_W-1:0]     sel_end;
    logic [DSEC_W-1:0]    sel_adj;
    logic [IDX_W-1:0]     sel_idx;
    logic [IDX_W+2:0]     sel_idx_ext;
    logic [SEC_W-1:0]     end2;
    logic [SEC_W-1:0]     avail;
    logic                 fits;
    logic [DSEC_W-1:0]    dsec;
    logic                 out_we;

    // Table write for a new disk: its end block and the offset that turns
    // an array sector straight into a device sector.
    assign table_full  = !(count_reg < CNT_W'(MAX_DISKS));
    assign new_end     = {1'b0, total_reg} + {{(END_W - SIZE_W){1'b0}}, size_reg};
    assign new_adj     = {1'b0, offset_reg} - {total_reg[DSEC_W-2:0], 1'b0};
    assign add_idx_ext = {3'b000, count_reg[IDX_W-1:0]};

    // Compare the current block against every table entry.
    assign block = sec_reg[SEC_W-1:1];
    assign n_ok  = n_reg < CNT_W'(MAX_DISKS);

    always_comb
    begin
        for (int i = 0; i < MAX_DISKS; i++)
        begin
            below_vec[i] = CNT_W'(i) < count_reg;
            hit_next[i]  = below_vec[i] && n_ok
                           && (block >= {1'b0, start_reg[i]})
                           && (block < end_reg[i]);
        end
    end

    // The lowest matching disk serves the segment.
    assign first_hit = hit_reg & (~hit_reg + 1'b1);
    assign hit_any   = |hit_reg;

    always_comb
    begin
        sel_end = '0;
        sel_adj = '0;
        sel_idx = '0;
        for (int i = 0; i < MAX_DISKS; i++)
        begin
            if (first_hit[i])
            begin
                sel_end = sel_end | end_reg[i];
                sel_adj = sel_adj | adj_reg[i];
                sel_idx = sel_idx | IDX_W'(i);
            end
        end
    end

    assign sel_idx_ext = {3'b000, sel_idx};
    assign end2        = {sel_end, 1'b0};
    assign avail       = end2 - sec_reg;
    assign fits        = secrem_reg <= {1'b0, end2};
    assign dsec        = sec_reg[DSEC_W-1:0] + sel_adj;

    assign sts.out_free  = !m_tvalid_reg || m_tready;
    assign sts.emit_last = !hit_any || fits;
    assign out_we        = cmd.add || cmd.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            total_reg    <= '0;
            n_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                total_reg <= '0;
            end
            else if (cmd.add && !table_full)
            begin
                count_reg <= count_reg + 1'b1;
                total_reg <= total_reg + TOTAL_W'(size_reg);
            end

            if (cmd.load)
            begin
                n_reg <= '0;
            end
            else if (cmd.emit && hit_any && !fits)
            begin
                n_reg <= n_reg + 1'b1;
            end

            if (out_we)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add && !table_full)
        begin
            start_reg[count_reg[IDX_W-1:0]] <= total_reg;
            end_reg[count_reg[IDX_W-1:0]]   <= new_end;
            adj_reg[count_reg[IDX_W-1:0]]   <= new_adj;
        end

        if (cmd.load)
        begin
            size_reg   <= s_tdata[IN_SIZE_LO +: SIZE_W];
            offset_reg <= s_tdata[IN_OFS_LO +: OFS_W];
            sec_reg    <= {1'b0, s_tdata[IN_START_LO +: START_W]};
            rem_reg    <= s_tdata[IN_LEN_LO +: LEN_W];
        end
        else if (cmd.emit && hit_any && !fits)
        begin
            // Carry on at the first sector past this disk's end.
            sec_reg <= end2;
            rem_reg <= rem_reg - avail[LEN_W-1:0];
        end

        if (cmd.lookup)
        begin
            hit_reg    <= hit_next;
            secrem_reg <= {1'b0, sec_reg} + SECREM_W'(rem_reg);
        end

        if (cmd.add)
        begin
            out_idx_reg  <= table_full ? '0 : add_idx_ext[IDX_OUT_W-1:0];
            out_dsec_reg <= '0;
            out_seg_reg  <= '0;
            out_stat_reg <= table_full ? STAT_FULL : STAT_ADDED;
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit)
        begin
            if (!hit_any)
            begin
                out_idx_reg  <= '0;
                out_dsec_reg <= '0;
                out_seg_reg  <= rem_reg;
                out_stat_reg <= STAT_RANGE;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_idx_reg  <= sel_idx_ext[IDX_OUT_W-1:0];
                out_dsec_reg <= dsec;
                out_seg_reg  <= fits ? rem_reg : avail[LEN_W-1:0];
                out_stat_reg <= STAT_MAPPED;
                out_last_reg <= fits;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                       out_seg_reg, out_dsec_reg, out_idx_reg};
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DISKS))
        else $error("disk count beyond table depth");

    a_hit_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (hit_reg & ~below_vec) == '0)
        else $error("match on a table entry that was never added");

    a_split_progress: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && hit_any && !fits
            |-> avail != '0 && avail < {{(SEC_W - LEN_W){1'b0}}, rem_reg})
        else $error("split segment does not shorten the request");

endmodule

@@ test/linear_concat_sector_mapper_core_tb.sv @@
// Self-checking testbench for linear_concat_sector_mapper_core.
// Depends on lcsm_pkg and the RTL of the mapper; predicts every result with a
// scoreboard class and drives both stream channels with random idling.
`timescale 1ns / 1ps

module linear_concat_sector_mapper_core_tb;

    import lcsm_pkg::*;

    localparam int NDISK = MAX_DISKS_DEF;
    localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;
    localparam logic [SIZE_W-1:0] SIZE_ALL = '1;
    localparam logic [OFS_W-1:0] OFS_ALL = '1;
    localparam logic [START_W-1:0] START_ALL = '1;
    localparam logic [LEN_W-1:0] LEN_ALL = '1;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 257;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] disk_index;
        logic [DSEC_W-1:0]    device_sector;
        logic [LEN_W-1:0]     segment_sectors;
        logic [STAT_W-1:0]    status;
        logic                 last;
    } segment_result_t;

    // Holds the disk table as the block should see it and the queue of
    // segment results still owed by the block.
    class sector_map_scoreboard;
        bit [SIZE_W-1:0]  size_tab[NDISK];
        bit [TOTAL_W-1:0] start_tab[NDISK];
        bit [OFS_W-1:0]   ofs_tab[NDISK];
        int unsigned      disk_cnt;
        bit [TOTAL_W-1:0] total;
        segment_result_t  owed_q[$];
        int unsigned      errors;

        function int find_member(bit [63:0] blk);
            bit [63:0] lo;
            bit [63:0] hi;
            for (int i = 0; i < disk_cnt; i++) begin
                lo = 64'(start_tab[i]);
                hi = lo + 64'(size_tab[i]);
                if (size_tab[i] != 0 && blk >= lo && blk < hi)
                    return i;
            end
            return -1;
        endfunction

        function void push_result(bit [63:0] idx, bit [63:0] dsec, bit [63:0] seg,
                                  logic [STAT_W-1:0] st, bit last);
            segment_result_t r;
            r.disk_index      = idx[IDX_OUT_W-1:0];
            r.device_sector   = dsec[DSEC_W-1:0];
            r.segment_sectors = seg[LEN_W-1:0];
            r.status          = st;
            r.last            = last;
            owed_q.push_back(r);
        endfunction

        function void note_request(logic [ACT_W-1:0] act, bit [SIZE_W-1:0] size,
                                   bit [OFS_W-1:0] ofs, bit [START_W-1:0] start,
                                   bit [LEN_W-1:0] len);
            bit [63:0] sec;
            bit [63:0] rem;
            bit [63:0] lo2;
            bit [63:0] hi2;
            bit [63:0] avail;
            bit [63:0] dsec;
            int        d;
            int        nseg;
            bit        done;
            case (act)
                ACT_ADD:
                begin
                    if (disk_cnt >= NDISK) begin
                        push_result(64'd0, 64'd0, 64'd0, STAT_FULL, 1'b1);
                    end else begin
                        size_tab[disk_cnt]  = size;
                        start_tab[disk_cnt] = total;
                        ofs_tab[disk_cnt]   = ofs;
                        push_result(64'(disk_cnt), 64'd0, 64'd0, STAT_ADDED, 1'b1);
                        disk_cnt++;
                        total = total + size;
                    end
                end
                ACT_CLEAR:
                begin
                    disk_cnt = 0;
                    total    = '0;
                end
                ACT_MAP:
                begin
                    sec  = 64'(start);
                    rem  = 64'(len);
                    nseg = 0;
                    done = 1'b0;
                    while (!done) begin
                        // Past the segment limit the remainder counts as out of range.
                        d = (nseg < NDISK) ? find_member(sec >> 1) : -1;
                        if (d < 0) begin
                            push_result(64'd0, 64'd0, rem, STAT_RANGE, 1'b1);
                            done = 1'b1;
                        end else begin
                            lo2   = 64'(start_tab[d]) << 1;
                            hi2   = (64'(start_tab[d]) + 64'(size_tab[d])) << 1;
                            avail = hi2 - sec;
                            dsec  = (sec - lo2) + 64'(ofs_tab[d]);
                            if (rem <= avail) begin
                                push_result(64'(d), dsec, rem, STAT_MAPPED, 1'b1);
                                done = 1'b1;
                            end else begin
                                push_result(64'(d), dsec, avail, STAT_MAPPED, 1'b0);
                                nseg++;
                                sec = sec + avail;
                                rem = rem - avail;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(segment_result_t got);
            segment_result_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result idx=%0d sector=%0d len=%0d status=%0d last=%0d",
                         $time, got.disk_index, got.device_sector, got.segment_sectors,
                         got.status, got.last);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.disk_index !== want.disk_index) begin
                $display("%0t: disk_index expected %0d actual %0d",
                         $time, want.disk_index, got.disk_index);
                errors++;
            end
            if (got.device_sector !== want.device_sector) begin
                $display("%0t: device_sector expected %0d actual %0d",
                         $time, want.device_sector, got.device_sector);
                errors++;
            end
            if (got.segment_sectors !== want.segment_sectors) begin
                $display("%0t: segment_sectors expected %0d actual %0d",
                         $time, want.segment_sectors, got.segment_sectors);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  m_tlast;

    sector_map_scoreboard sb = new();
    bit long_hold_req;
    int burst_left;

    linear_concat_sector_mapper_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one request and returns at the edge where it is taken, with
    // s_tvalid still high; the caller decides whether a gap follows.
    task automatic send_request(logic [ACT_W-1:0] act, logic [SIZE_W-1:0] size,
                                logic [OFS_W-1:0] ofs, logic [START_W-1:0] start,
                                logic [LEN_W-1:0] len);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[IN_SIZE_LO +: SIZE_W]   = size;
        word[IN_OFS_LO +: OFS_W]     = ofs;
        word[IN_START_LO +: START_W] = start;
        word[IN_LEN_LO +: LEN_W]     = len;
        s_tdata  <= word;
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(act, size, ofs, start, len);
    endtask

    task automatic issue(logic [ACT_W-1:0] act, logic [SIZE_W-1:0] size,
                         logic [OFS_W-1:0] ofs, logic [START_W-1:0] start,
                         logic [LEN_W-1:0] len);
        int gap;
        send_request(act, size, ofs, start, len);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 7);
        end
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        bit [63:0] near_end;
        issue(ACT_MAP, '0, '0, START_ALL, LEN_ALL);
        issue(ACT_MAP, '0, '0, '0, '0);
        issue(ACT_IGNORED, SIZE_ALL, OFS_ALL, START_ALL, LEN_ALL);
        // An empty disk first: it must never be chosen.
        issue(ACT_ADD, '0, OFS_ALL, '0, '0);
        issue(ACT_ADD, 40'd1, '0, '0, '0);
        issue(ACT_ADD, 40'd3, 40'd7, '0, '0);
        issue(ACT_ADD, SIZE_ALL, OFS_ALL, '0, '0);
        issue(ACT_MAP, '0, '0, '0, '0);
        issue(ACT_MAP, '0, '0, 44'd1, 23'd10);
        // Crosses the end of the largest disk; the sector sum wraps at 41 bits.
        near_end = ((64'd4 + SIZE_ALL) << 1) - 3;
        issue(ACT_MAP, '0, '0, near_end[START_W-1:0], 23'd10);
        issue(ACT_CLEAR, '0, '0, '0, '0);
        for (int i = 0; i < NDISK; i++)
            issue(ACT_ADD, 40'($urandom_range(1, 2)), 40'($urandom_range(0, 1000)), '0, '0);
        issue(ACT_ADD, 40'd5, 40'd5, '0, '0);
        // Runs through every disk and hits the segment limit.
        issue(ACT_MAP, '0, '0, '0, LEN_ALL);
        issue(ACT_CLEAR, '0, '0, '0, '0);
        issue(ACT_MAP, '0, '0, 44'd5, 23'd5);
    endtask

    task automatic run_random(int count);
        int        done_cnt;
        int        pick;
        int        d;
        bit [63:0] size;
        bit [63:0] ofs;
        bit [63:0] start;
        bit [63:0] len;
        done_cnt = 0;
        while (done_cnt < count) begin
            if (done_cnt == 90)
                long_hold_req = 1'b1;
            if (done_cnt == 180)
                wait_until_drained();
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                issue(ACT_IGNORED, SIZE_W'(rand64()), OFS_W'(rand64()),
                      START_W'(rand64()), LEN_W'(rand64()));
            end else if (pick < 7 || (sb.disk_cnt >= NDISK && pick < 35)) begin
                issue(ACT_CLEAR, SIZE_W'(rand64()), OFS_W'(rand64()),
                      START_W'(rand64()), LEN_W'(rand64()));
                done_cnt++;
            end else if (pick < 27) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    size = 0;
                else if (pick < 80)
                    size = 64'($urandom_range(1, 64));
                else if (pick < 92)
                    size = 64'($urandom_range(65, 100000));
                else
                    size = rand64();
                ofs = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, 5000)) : rand64();
                issue(ACT_ADD, size[SIZE_W-1:0], ofs[OFS_W-1:0],
                      START_W'(rand64()), LEN_W'(rand64()));
                done_cnt++;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    start = rand64() % ((64'(sb.total) << 1) + 9);
                end else if (pick < 85 && sb.disk_cnt > 0) begin
                    // Land close to the end of one disk to provoke a split.
                    d = int'($urandom_range(0, sb.disk_cnt - 1));
                    start = (64'(sb.start_tab[d]) + 64'(sb.size_tab[d])) << 1;
                    start = start - 64'($urandom_range(0, 4));
                end else begin
                    start = rand64();
                end
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    len = 0;
                else if (pick < 60)
                    len = 64'($urandom_range(1, 16));
                else if (pick < 92)
                    len = 64'($urandom_range(0, 300));
                else
                    len = rand64();
                issue(ACT_MAP, SIZE_W'(rand64()), OFS_W'(rand64()),
                      start[START_W-1:0], len[LEN_W-1:0]);
                done_cnt++;
            end
        end
    endtask

    // Receiver: changes its stall pattern at random intervals, and holds
    // off completely for a long stretch when the sender asks for it.
    initial
    begin : rx_proc
        int mode;
        int span;
        int hold_left;
        int phase;
        m_tready = 1'b0;
        span = 0;
        hold_left = 0;
        phase = 0;
        mode = 0;
        forever begin
            @(posedge clk);
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 80);
                end
                span--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= (phase % 4 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        segment_result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.disk_index      = m_tdata[0 +: IDX_OUT_W];
            got.device_sector   = m_tdata[IDX_OUT_W +: DSEC_W];
            got.segment_sectors = m_tdata[IDX_OUT_W + DSEC_W +: LEN_W];
            got.status          = m_tuser;
            got.last            = m_tlast;
            sb.check_result(got);
        end
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        long_hold_req = 1'b0;
        burst_left    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_ITEMS);
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ linear_concat_sector_mapper_core.f @@
rtl/lcsm_pkg.sv
rtl/lcsm_ctrl.sv
rtl/lcsm_dp.sv
rtl/linear_concat_sector_mapper_core.sv
test/linear_concat_sector_mapper_core_tb.sv
